/* src/volume_fade_ramp_macros.svh */
// assertion macros shared by the volume fade ramp rtl
`ifndef VOLUME_FADE_RAMP_MACROS_SVH
`define VOLUME_FADE_RAMP_MACROS_SVH

// same-cycle implication, clocked on aclk, off during reset
`define VFR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on aclk, off during reset
`define VFR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/vfr_pkg.sv */
// shared constants, types and sequencer states of the volume fade ramp
`default_nettype none
package vfr_pkg;
    localparam int TIME_BITS   = 16;
    localparam int VOL_W       = 7;
    localparam int FACTOR_W    = 12;
    localparam int TICKS_W     = 16;
    localparam int STEP_W      = 13;
    localparam int FRAC_BITS   = 5;
    localparam int UNITY_SHIFT = 10;
    localparam int MUL_B_W     = (TIME_BITS > FACTOR_W) ? TIME_BITS : FACTOR_W;
    localparam int PROD_W      = VOL_W + MUL_B_W;
    localparam int DIV_W       = VOL_W + TIME_BITS;
    localparam int DVS_W       = VOL_W + 1;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 8;
    localparam int CFG_ADDR_W  = 1;

    localparam logic [VOL_W-1:0]            VOL_MAX   = 7'd127;
    localparam logic signed [DVS_W:0]       STOP_DEST = -9'sd4;
    localparam logic [TIME_BITS-1:0]        TIME_MASK = '1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_ORIG_VOL  = 1'b0,
        CFG_START_VOL = 1'b1
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_VOL,
        S_CMD,
        S_EVAL,
        S_MUL_RT,
        S_DIV_RT_GO,
        S_DIV_RT_WAIT,
        S_SELECT,
        S_DIV_FAST_WAIT,
        S_DIV_SLOW_WAIT,
        S_TICK,
        S_OUT
    } state_t;

    typedef struct packed {
        logic                start;
        logic [DIV_W-1:0]    dividend;
        logic [DVS_W-1:0]    divisor;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [DIV_W-1:0]    quotient;
    } div_rsp_t;
endpackage
`default_nettype wire

/* src/vfr_div.sv */
// shared restoring divider, one quotient bit per cycle
`default_nettype none
module vfr_div (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire vfr_pkg::div_req_t req,
    output vfr_pkg::div_rsp_t      rsp
);
    import vfr_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [DIV_W-1:0]    quo_reg, quo_next;
    logic [DVS_W-1:0]    rem_reg, rem_next;
    logic [DVS_W-1:0]    dvs_reg, dvs_next;
    logic [DVS_W:0]      shifted;
    logic                fits;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        shifted   = {rem_reg, quo_reg[DIV_W-1]};
        fits      = shifted >= {1'b0, dvs_reg};
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_W);
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end else if (busy_reg) begin
            rem_next = fits ? DVS_W'(shifted - {1'b0, dvs_reg}) : shifted[DVS_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;
endmodule
`default_nettype wire

/* src/volume_fade_ramp.sv */
// volume fade ramp: top level with command and tick sequencer
// A tick request (tuser 0) advances a running ramp and, when the volume moves,
// gives one result with the new volume; at the end of a fade-out that result also raises stop.
// A command request (tuser 1) sets up a ramp through a 7x16 multiplier and one shared
// bit-serial divider of 23 quotient bits; retiming a running ramp takes two divisions back
// to back. A zero fade time applies the volume, or stops the voice, with no ramp.
// A finished result waits in the output register while the next request is taken.
// Registers are to be written with cfg_wr_en only at an idle time; the block itself does
// not enforce this. Writing the start volume also loads the current volume.
`default_nettype none
`include "volume_fade_ramp_macros.svh"
module volume_fade_ramp (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // volume_factor[11:0], fade_out_stop[12], fade_ticks[28:13], retime_running[29], zero
    input  wire logic [vfr_pkg::S_TDATA_W-1:0]    s_tdata,
    // req_type
    input  wire logic                             s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // volume_out[6:0], stop_voice[7]
    output logic [vfr_pkg::M_TDATA_W-1:0]         m_tdata,
    // volume_valid
    output logic                                  m_tuser,
    input  wire logic                             cfg_wr_en,
    input  wire logic [vfr_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [vfr_pkg::VOL_W-1:0]        cfg_wdata
);
    import vfr_pkg::*;

    state_t                  state_reg, state_next;
    logic [VOL_W-1:0]        orig_vol_reg, orig_vol_next;
    logic [VOL_W-1:0]        start_vol_reg, start_vol_next;
    logic [VOL_W-1:0]        cur_reg, cur_next;
    logic                    ramp_reg, ramp_next;
    logic [VOL_W-1:0]        target_reg, target_next;
    logic                    stop_end_reg, stop_end_next;
    logic signed [STEP_W-1:0] step_reg, step_next;
    logic                    slow_reg, slow_next;
    logic [TIME_BITS-1:0]    interval_reg, interval_next;
    logic [TIME_BITS-1:0]    countdown_reg, countdown_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [VOL_W-1:0]        m_vol_reg, m_vol_next;
    logic                    m_valid_reg, m_valid_next;
    logic                    m_stop_reg, m_stop_next;

    // request and work payload
    logic [FACTOR_W-1:0]     factor_reg, factor_next;
    logic                    fstop_reg, fstop_next;
    logic [TICKS_W-1:0]      ticks_reg, ticks_next;
    logic                    retime_reg, retime_next;
    logic [PROD_W-1:0]       prod_reg, prod_next;
    logic [VOL_W-1:0]        vol_reg, vol_next;
    logic [DIV_W-1:0]        dt_reg, dt_next;
    logic [VOL_W-1:0]        res_vol_reg, res_vol_next;
    logic                    res_valid_reg, res_valid_next;
    logic                    res_stop_reg, res_stop_next;

    div_req_t                div_req;
    div_rsp_t                div_rsp;

    logic [VOL_W-1:0]        mul_a;
    logic [MUL_B_W-1:0]      mul_b;
    logic [PROD_W-1:0]       prod_shift;
    logic [TIME_BITS-1:0]    dt_in;
    logic signed [VOL_W:0]   change;
    logic [VOL_W-1:0]        abs_change;
    logic signed [DVS_W:0]   dest_rt;
    logic signed [DVS_W:0]   remain;
    logic [DVS_W-1:0]        abs_remain;
    logic [TIME_BITS-1:0]    cnt_dec;
    logic signed [13:0]      acc;
    logic signed [DVS_W:0]   nv_raw;
    logic signed [DVS_W:0]   dest_tk;
    logic signed [DVS_W:0]   nv;

    vfr_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_stop_reg, m_vol_reg};
    assign m_tuser  = m_valid_reg;

    always_comb begin
        dt_in      = TIME_BITS'(ticks_reg);
        prod_shift = prod_reg >> UNITY_SHIFT;
        change     = $signed({1'b0, vol_reg}) - $signed({1'b0, cur_reg});
        abs_change = change[VOL_W] ? VOL_W'(-change) : VOL_W'(change);
        dest_rt    = stop_end_reg ? STOP_DEST : $signed({2'b00, target_reg});
        remain     = $signed({2'b00, vol_reg}) - dest_rt;
        abs_remain = remain[DVS_W] ? DVS_W'(-remain) : DVS_W'(remain);
        cnt_dec    = countdown_reg - 1'b1;
        acc        = $signed({2'b00, cur_reg, {FRAC_BITS{1'b0}}})
                     + $signed({step_reg[STEP_W-1], step_reg});
        if (step_reg > -13'sd2 && step_reg < 13'sd2) begin
            nv_raw = $signed({2'b00, cur_reg}) + $signed(step_reg[DVS_W:0]);
        end else begin
            nv_raw = acc[13:FRAC_BITS];
        end
        dest_tk = stop_end_reg ? '0 : $signed({2'b00, target_reg});
        if ((step_reg > 0 && dest_tk < nv_raw) || (step_reg < 0 && dest_tk >= nv_raw)) begin
            nv = dest_tk;
        end else begin
            nv = nv_raw;
        end
        if (state_reg == S_MUL_VOL) begin
            mul_a = orig_vol_reg;
            mul_b = MUL_B_W'(factor_reg);
        end else begin
            mul_a = abs_change;
            mul_b = MUL_B_W'(dt_in);
        end
    end

    always_comb begin
        state_next     = state_reg;
        orig_vol_next  = orig_vol_reg;
        start_vol_next = start_vol_reg;
        cur_next       = cur_reg;
        ramp_next      = ramp_reg;
        target_next    = target_reg;
        stop_end_next  = stop_end_reg;
        step_next      = step_reg;
        slow_next      = slow_reg;
        interval_next  = interval_reg;
        countdown_next = countdown_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_vol_next     = m_vol_reg;
        m_valid_next   = m_valid_reg;
        m_stop_next    = m_stop_reg;
        factor_next    = factor_reg;
        fstop_next     = fstop_reg;
        ticks_next     = ticks_reg;
        retime_next    = retime_reg;
        prod_next      = prod_reg;
        vol_next       = vol_reg;
        dt_next        = dt_reg;
        res_vol_next   = res_vol_reg;
        res_valid_next = res_valid_reg;
        res_stop_next  = res_stop_reg;
        div_req        = '0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_ORIG_VOL:  orig_vol_next = cfg_wdata;
                CFG_START_VOL: begin
                    start_vol_next = cfg_wdata;
                    cur_next       = cfg_wdata;
                end
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    factor_next = s_tdata[11:0];
                    fstop_next  = s_tdata[12];
                    ticks_next  = s_tdata[28:13];
                    retime_next = s_tdata[29];
                    state_next  = s_tuser ? S_MUL_VOL : S_TICK;
                end
            end
            S_MUL_VOL: begin
                prod_next  = PROD_W'(mul_a) * PROD_W'(mul_b);
                state_next = S_CMD;
            end
            S_CMD: begin
                if (fstop_reg) begin
                    vol_next = '0;
                end else if (prod_shift > PROD_W'(VOL_MAX)) begin
                    vol_next = VOL_MAX;
                end else begin
                    vol_next = prod_shift[VOL_W-1:0];
                end
                state_next = S_EVAL;
            end
            S_EVAL: begin
                if (dt_in == '0) begin
                    ramp_next = 1'b0;
                    if (fstop_reg) begin
                        res_vol_next   = '0;
                        res_valid_next = 1'b0;
                        res_stop_next  = 1'b1;
                    end else begin
                        cur_next       = vol_reg;
                        res_vol_next   = vol_reg;
                        res_valid_next = 1'b1;
                        res_stop_next  = 1'b0;
                    end
                    state_next = S_OUT;
                end else if (change == '0) begin
                    ramp_next  = 1'b0;
                    state_next = S_IDLE;
                end else if (ramp_reg && retime_reg) begin
                    if (remain == '0) begin
                        ramp_next      = 1'b0;
                        cur_next       = vol_reg;
                        res_vol_next   = vol_reg;
                        res_valid_next = 1'b1;
                        res_stop_next  = 1'b0;
                        state_next     = S_OUT;
                    end else begin
                        state_next = S_MUL_RT;
                    end
                end else begin
                    dt_next    = DIV_W'(dt_in);
                    state_next = S_SELECT;
                end
            end
            S_MUL_RT: begin
                prod_next  = PROD_W'(mul_a) * PROD_W'(mul_b);
                state_next = S_DIV_RT_GO;
            end
            S_DIV_RT_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'(prod_reg);
                div_req.divisor  = abs_remain;
                state_next       = S_DIV_RT_WAIT;
            end
            S_DIV_RT_WAIT: begin
                if (div_rsp.done) begin
                    dt_next    = (div_rsp.quotient == '0) ? DIV_W'(1) : div_rsp.quotient;
                    state_next = S_SELECT;
                end
            end
            S_SELECT: begin
                div_req.start = 1'b1;
                if (DIV_W'(abs_change) >= dt_reg) begin
                    div_req.dividend = DIV_W'({abs_change, {FRAC_BITS{1'b0}}});
                    div_req.divisor  = DVS_W'(dt_reg);
                    state_next       = S_DIV_FAST_WAIT;
                end else begin
                    div_req.dividend = dt_reg;
                    div_req.divisor  = DVS_W'(abs_change);
                    state_next       = S_DIV_SLOW_WAIT;
                end
            end
            S_DIV_FAST_WAIT: begin
                if (div_rsp.done) begin
                    step_next      = change[VOL_W] ? -STEP_W'(div_rsp.quotient)
                                                   : STEP_W'(div_rsp.quotient);
                    slow_next      = 1'b0;
                    countdown_next = '0;
                    target_next    = vol_reg;
                    stop_end_next  = fstop_reg;
                    ramp_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_DIV_SLOW_WAIT: begin
                if (div_rsp.done) begin
                    if (div_rsp.quotient > DIV_W'(TIME_MASK)) begin
                        interval_next  = TIME_MASK;
                        countdown_next = TIME_MASK;
                    end else begin
                        interval_next  = div_rsp.quotient[TIME_BITS-1:0];
                        countdown_next = div_rsp.quotient[TIME_BITS-1:0];
                    end
                    step_next     = change[VOL_W] ? -13'sd1 : 13'sd1;
                    slow_next     = 1'b1;
                    target_next   = vol_reg;
                    stop_end_next = fstop_reg;
                    ramp_next     = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_TICK: begin
                if (!ramp_reg) begin
                    state_next = S_IDLE;
                end else if (countdown_reg != '0 && cnt_dec != '0) begin
                    countdown_next = cnt_dec;
                    state_next     = S_IDLE;
                end else begin
                    countdown_next = '0;
                    cur_next       = nv[VOL_W-1:0];
                    res_vol_next   = nv[VOL_W-1:0];
                    res_valid_next = 1'b1;
                    if (nv == dest_tk) begin
                        ramp_next     = 1'b0;
                        res_stop_next = stop_end_reg;
                    end else begin
                        res_stop_next = 1'b0;
                        if (slow_reg) begin
                            countdown_next = interval_reg;
                        end
                    end
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_vol_next    = res_vol_reg;
                    m_valid_next  = res_valid_reg;
                    m_stop_next   = res_stop_reg;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            orig_vol_reg  <= VOL_MAX;
            start_vol_reg <= '0;
            cur_reg       <= '0;
            ramp_reg      <= 1'b0;
            target_reg    <= '0;
            stop_end_reg  <= 1'b0;
            step_reg      <= '0;
            slow_reg      <= 1'b0;
            interval_reg  <= '0;
            countdown_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            orig_vol_reg  <= orig_vol_next;
            start_vol_reg <= start_vol_next;
            cur_reg       <= cur_next;
            ramp_reg      <= ramp_next;
            target_reg    <= target_next;
            stop_end_reg  <= stop_end_next;
            step_reg      <= step_next;
            slow_reg      <= slow_next;
            interval_reg  <= interval_next;
            countdown_reg <= countdown_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_vol_reg     <= m_vol_next;
        m_valid_reg   <= m_valid_next;
        m_stop_reg    <= m_stop_next;
        factor_reg    <= factor_next;
        fstop_reg     <= fstop_next;
        ticks_reg     <= ticks_next;
        retime_reg    <= retime_next;
        prod_reg      <= prod_next;
        vol_reg       <= vol_next;
        dt_reg        <= dt_next;
        res_vol_reg   <= res_vol_next;
        res_valid_reg <= res_valid_next;
        res_stop_reg  <= res_stop_next;
    end

    `VFR_ASSERT_IMP(a_ramp_step_nonzero, ramp_reg, step_reg != '0,
        "running ramp has zero step")
    `VFR_ASSERT_IMP(a_slow_unit_step, ramp_reg && slow_reg,
        step_reg == 13'sd1 || step_reg == -13'sd1, "slow ramp step is not one")
    `VFR_ASSERT_IMP(a_stop_only_result, m_tvalid_reg && !m_valid_reg,
        m_stop_reg && m_vol_reg == '0, "result without volume is not a stop")
    `VFR_ASSERT_IMP(a_div_done_waited, div_rsp.done,
        state_reg == S_DIV_RT_WAIT || state_reg == S_DIV_FAST_WAIT
        || state_reg == S_DIV_SLOW_WAIT, "divider finished with no one waiting")
    `VFR_ASSERT_NXT(a_busy_after_request, s_tvalid && s_tready, !s_tready,
        "request taken while still working")
endmodule
`default_nettype wire

/* tb/sv/vfr_fade_checker.sv */
// checker for the volume fade ramp: predicts each result from the accepted requests and compares
`default_nettype none
module vfr_fade_checker (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    input  wire logic                            s_tready,
    // volume_factor[11:0], fade_out_stop[12], fade_ticks[28:13], retime_running[29], zero
    input  wire logic [vfr_pkg::S_TDATA_W-1:0]   s_tdata,
    // req_type
    input  wire logic                            s_tuser,
    input  wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    // volume_out[6:0], stop_voice[7]
    input  wire logic [vfr_pkg::M_TDATA_W-1:0]   m_tdata,
    // volume_valid
    input  wire logic                            m_tuser,
    input  wire logic                            cfg_wr_en,
    input  wire logic [vfr_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [vfr_pkg::VOL_W-1:0]       cfg_wdata,
    output int                                   fail_count,
    output int                                   pending_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import vfr_pkg::*;

    typedef struct packed {
        logic [1:0]         pad;
        logic               retime;
        logic [TICKS_W-1:0] ticks;
        logic               fade_out;
        logic [FACTOR_W-1:0] factor;
    } fade_req_t;

    typedef struct packed {
        logic [VOL_W-1:0] vol;
        logic             valid;
        logic             stop;
    } vol_result_t;

    logic [VOL_W-1:0]     orig_vol;
    logic [VOL_W-1:0]     cur_vol;
    bit                   ramp_on;
    int                   tgt_vol;
    bit                   stop_end;
    int                   step;
    bit                   slow;
    logic [TIME_BITS-1:0] interval;
    logic [TIME_BITS-1:0] countdown;
    vol_result_t          expected_volumes[$];
    vol_result_t          want;
    vol_result_t          got;

    initial begin
        fail_count = 0;
        pending_count = 0;
    end

    function automatic void predict_fade(input logic is_cmd, input fade_req_t req);
        longint vol;
        longint dt;
        longint change;
        longint mag;
        longint dest;
        longint remain;
        longint iv;
        int     cur_i;
        int     tick_dest;
        int     nv;
        if (is_cmd) begin
            if (req.fade_out) begin
                vol = 0;
            end else begin
                vol = (longint'(orig_vol) * longint'(req.factor)) >> UNITY_SHIFT;
                if (vol > longint'(VOL_MAX)) vol = longint'(VOL_MAX);
            end
            dt = longint'(req.ticks & TIME_MASK);
            if (dt == 0) begin
                ramp_on = 1'b0;
                if (req.fade_out) begin
                    expected_volumes.push_back(vol_result_t'{'0, 1'b0, 1'b1});
                end else begin
                    cur_vol = vol[VOL_W-1:0];
                    expected_volumes.push_back(vol_result_t'{vol[VOL_W-1:0], 1'b1, 1'b0});
                end
                return;
            end
            change = vol - longint'(cur_vol);
            if (change == 0) begin
                ramp_on = 1'b0;
                return;
            end
            if (ramp_on && req.retime) begin
                dest = stop_end ? longint'(STOP_DEST) : longint'(tgt_vol);
                remain = vol - dest;
                if (remain == 0) begin
                    ramp_on = 1'b0;
                    cur_vol = vol[VOL_W-1:0];
                    expected_volumes.push_back(vol_result_t'{vol[VOL_W-1:0], 1'b1, 1'b0});
                    return;
                end
                dt = (change * dt) / remain;
                if (dt < 0) dt = -dt;
                if (dt <= 0) dt = 1;
            end
            mag = (change < 0) ? -change : change;
            if (mag >= dt) begin
                step = int'((change * (1 << FRAC_BITS)) / dt);
                slow = 1'b0;
                countdown = '0;
            end else begin
                iv = dt / mag;
                if (iv > longint'(TIME_MASK)) iv = longint'(TIME_MASK);
                interval = iv[TIME_BITS-1:0];
                slow = 1'b1;
                countdown = interval;
                step = (change > 0) ? 1 : -1;
            end
            tgt_vol = int'(vol);
            stop_end = req.fade_out;
            ramp_on = 1'b1;
        end else begin
            if (!ramp_on) return;
            if (countdown != 0) begin
                countdown = countdown - 1'b1;
                if (countdown != 0) return;
            end
            tick_dest = stop_end ? 0 : tgt_vol;
            cur_i = int'(cur_vol);
            if (step > -2 && step < 2) nv = cur_i + step;
            else nv = (cur_i * (1 << FRAC_BITS) + step) >>> FRAC_BITS;
            if ((step > 0 && tick_dest < nv) || (step < 0 && tick_dest >= nv)) nv = tick_dest;
            cur_vol = nv[VOL_W-1:0];
            if (nv == tick_dest) begin
                ramp_on = 1'b0;
                expected_volumes.push_back(vol_result_t'{cur_vol, 1'b1, stop_end});
                return;
            end
            if (slow) countdown = interval;
            expected_volumes.push_back(vol_result_t'{cur_vol, 1'b1, 1'b0});
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            orig_vol = VOL_MAX;
            cur_vol = '0;
            ramp_on = 1'b0;
            tgt_vol = 0;
            stop_end = 1'b0;
            step = 0;
            slow = 1'b0;
            interval = '0;
            countdown = '0;
            expected_volumes.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = vol_result_t'{m_tdata[VOL_W-1:0], m_tuser, m_tdata[VOL_W]};
                if (expected_volumes.size() == 0) begin
                    $error("unexpected result: volume_out %0d, volume_valid %0d, stop_voice %0d",
                           got.vol, got.valid, got.stop);
                    fail_count++;
                end else begin
                    want = expected_volumes.pop_front();
                    if (got.vol !== want.vol) begin
                        $error("volume_out: expected %0d, actual %0d", want.vol, got.vol);
                        fail_count++;
                    end
                    if (got.valid !== want.valid) begin
                        $error("volume_valid: expected %0d, actual %0d", want.valid, got.valid);
                        fail_count++;
                    end
                    if (got.stop !== want.stop) begin
                        $error("stop_voice: expected %0d, actual %0d", want.stop, got.stop);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) predict_fade(s_tuser, fade_req_t'(s_tdata));
            if (cfg_wr_en) begin
                case (cfg_idx_t'(cfg_addr))
                    CFG_ORIG_VOL: begin
                        orig_vol = cfg_wdata;
                    end
                    CFG_START_VOL: begin
                        cur_vol = cfg_wdata;
                    end
                    default: begin
                    end
                endcase
            end
        end
        pending_count = expected_volumes.size();
    end
endmodule
`default_nettype wire

/* tb/sv/tb.sv */
// top of the volume fade ramp testbench: clock, reset, requests, configuration and verdict
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import vfr_pkg::*;

    localparam int SETTLE_CYCLES   = 100;
    localparam int PHASES          = 7;
    localparam int ITEMS_PER_PHASE = 75;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tuser;
    logic                   cfg_wr_en;
    logic [CFG_ADDR_W-1:0]  cfg_addr;
    logic [VOL_W-1:0]       cfg_wdata;
    int                     fail_count;
    int                     pending_count;
    bit                     steady;

    volume_fade_ramp u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    vfr_fade_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_request(input logic is_cmd, input logic [S_TDATA_W-1:0] data);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= is_cmd;
        s_tdata <= data;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic send_cmd(input logic [FACTOR_W-1:0] factor, input logic fade_out,
                            input logic [TICKS_W-1:0] ticks, input logic retime);
        send_request(1'b1, {2'b00, retime, ticks, fade_out, factor});
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_request(1'b0, {2'b00, 30'($urandom)});
    endtask

    task automatic send_random_cmd();
        logic [FACTOR_W-1:0] factor;
        logic [TICKS_W-1:0]  ticks;
        int                  r;
        if ($urandom_range(0, 1)) factor = FACTOR_W'($urandom_range(0, 1100));
        else factor = FACTOR_W'($urandom);
        r = $urandom_range(0, 99);
        if (r < 15) ticks = '0;
        else if (r < 65) ticks = TICKS_W'($urandom_range(1, 16));
        else if (r < 90) ticks = TICKS_W'($urandom_range(17, 300));
        else ticks = TICKS_W'($urandom);
        send_cmd(factor, $urandom_range(0, 99) < 20, ticks, $urandom_range(0, 99) < 35);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic configure(input logic [VOL_W-1:0] orig, input logic [VOL_W-1:0] start);
        cfg_idx_t first;
        first = ($urandom_range(0, 1) != 0) ? CFG_START_VOL : CFG_ORIG_VOL;
        cfg_wr_en <= 1'b1;
        cfg_addr <= first;
        cfg_wdata <= (first == CFG_ORIG_VOL) ? orig : start;
        @(negedge aclk);
        cfg_addr <= (first == CFG_ORIG_VOL) ? CFG_START_VOL : CFG_ORIG_VOL;
        cfg_wdata <= (first == CFG_ORIG_VOL) ? start : orig;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        repeat (2) @(negedge aclk);
    endtask

    initial begin : rx_side
        int gap;
        int stall_left;
        m_tready = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                gap = pick_gap();
                if (steady || gap == 0) begin
                    m_tready <= 1'b1;
                end else begin
                    m_tready <= 1'b0;
                    stall_left = gap - 1;
                end
            end
        end
    end

    initial begin
        #(5_000_000);
        $display("Test completed with failures");
        $finish;
    end

    initial begin : stimulus
        int orig_sel[PHASES];
        int start_sel[PHASES];
        int sent;
        int n;
        orig_sel = '{127, 0, 127, 1, 64, 0, 0};
        start_sel = '{0, 127, 127, 1, 100, 0, 0};
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        steady = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int p = 0; p < PHASES; p++) begin
            drain();
            if (p >= 5) begin
                orig_sel[p] = $urandom_range(0, 127);
                start_sel[p] = $urandom_range(0, 127);
            end
            configure(VOL_W'(orig_sel[p]), VOL_W'(start_sel[p]));
            steady = (p == 2);
            if (p == 0) begin
                // idle tick, then immediate sets with clamp and a retime with no ramp
                send_ticks(1);
                send_cmd(12'd512, 1'b0, 16'd0, 1'b1);
                send_cmd(12'd4095, 1'b0, 16'd0, 1'b0);
                send_cmd(12'd0, 1'b0, 16'd0, 1'b0);
                send_cmd(12'd0, 1'b1, 16'd0, 1'b0);
                // fade-out with nothing to fade
                send_cmd(12'd0, 1'b1, 16'd5, 1'b0);
                send_cmd(12'd1024, 1'b0, 16'd3, 1'b0);
                send_ticks(3);
                // slow ramp with a countdown between steps
                send_cmd(12'd1008, 1'b0, 16'd4, 1'b0);
                send_ticks(4);
                // retime onto the target already set
                send_cmd(12'd0, 1'b0, 16'd20, 1'b0);
                send_ticks(1);
                send_cmd(12'd0, 1'b0, 16'd10, 1'b1);
                // retime of a pending fade-out
                send_cmd(12'd4095, 1'b0, 16'd0, 1'b0);
                send_cmd(12'd0, 1'b1, 16'd200, 1'b0);
                send_cmd(12'd512, 1'b0, 16'd40, 1'b1);
                send_ticks(2);
                send_cmd(12'd0, 1'b1, 16'd2, 1'b0);
                send_ticks(3);
                send_cmd(12'd4095, 1'b0, 16'hFFFF, 1'b1);
            end
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                if ($urandom_range(0, 99) < 85) begin
                    send_random_cmd();
                    n = $urandom_range(0, 12);
                    send_ticks(n);
                    sent += n + 1;
                end else if ($urandom_range(0, 1)) begin
                    send_ticks(1);
                    sent++;
                end else begin
                    send_random_cmd();
                    sent++;
                end
            end
        end
        drain();

        if (fail_count == 0 && pending_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
`default_nettype wire

/* sim.f */
+incdir+src
src/vfr_pkg.sv
src/vfr_div.sv
src/volume_fade_ramp.sv
tb/sv/vfr_fade_checker.sv
tb/sv/tb.sv
